/* src/rfpe_pkg.sv */
package rfpe_pkg;

  // fixed field widths
  localparam int unsigned ID_FIELD_W  = 16;
  localparam int unsigned KEY_FIELD_W = 7;
  localparam int unsigned DUR_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // highest bit index of the identifier field
  localparam int unsigned ID_FIELD_MSB = 15;

  // parameter defaults and ranges
  localparam int unsigned ID_BITS_DEF  = 16;
  localparam int unsigned KEY_BITS_DEF = 7;
  localparam int unsigned ID_BITS_MAX  = 32;
  localparam int unsigned KEY_BITS_MAX = 16;

  // frame length cap in segments
  localparam int unsigned MAX_SEGMENTS = 48;

  // register reset values and the hold segment length
  localparam logic [DUR_W-1:0] START_DUR_RST = 16'd500;
  localparam logic [DUR_W-1:0] SHORT_DUR_RST = 16'd110;
  localparam logic [DUR_W-1:0] LONG_DUR_RST  = 16'd300;
  localparam logic [DUR_W-1:0] HOLD_DUR      = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DUR = 2'd0,
    REG_SHORT_DUR = 2'd1,
    REG_LONG_DUR  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_BIT,
    ST_HOLD
  } enc_state_e;

  typedef struct packed {
    logic [ID_FIELD_W-1:0]  remote_id;
    logic [KEY_FIELD_W-1:0] key_code;
    logic                   action;
    logic                   append_hold;
  } frame_t;

  typedef struct packed {
    logic             line_level;
    logic [DUR_W-1:0] duration_us;
    logic             last_segment;
  } segment_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DUR_W-1:0]     value;
  } cfg_wr_t;

endpackage

/* src/rfpe_chan_if.sv */
interface rfpe_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/rf_remote_pulse_encoder.sv */
// rf remote pulse encoder
//
// frame_i: one word is a frame request (remote_id, key_code, action, append_hold).
// seg_o:   one word per line segment (line_level, duration_us, last_segment).
// cfg_i:   register writes (index, value); 0 start, 1 short, 2 long duration.
//          always ready; other indexes are ignored. write only while idle.
//
// a frame is a start segment at the action level, then ID_BITS identifier bits
// and KEY_BITS key bits msb first, held in a shift register that moves one bit
// per emitted bit. a zero bit is two short segments (opposite level, then back),
// a one bit is one long segment at the opposite level, which flips the level.
// append_hold adds a final zero-length segment at the action level. frames are
// capped at 48 segments, the last one sent carries last_segment.
//
// after the accepting edge the sequencer enters the start state, and the start segment
// is registered from there once seg_o can advance. throughput: the sequencer emits one
// segment per cycle while seg_o is not stalled; a frame has 24 to 48 segments at default widths.
// frame_i is ready only while no frame is in progress.
// a stalled seg_o freezes the sequencer; the output register holds its word.
// reset clears the sequencer and output valid and restores the duration registers.
module rf_remote_pulse_encoder
  import rfpe_pkg::*;
#(
  parameter int unsigned ID_BITS  = ID_BITS_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rfpe_chan_if.sink    frame_i,
  rfpe_chan_if.sink    cfg_i,
  rfpe_chan_if.source  seg_o
);

  localparam int unsigned TOT_BITS = ID_BITS + KEY_BITS;
  localparam int unsigned BCW      = $clog2(TOT_BITS + 1);
  localparam int unsigned SCW      = $clog2(MAX_SEGMENTS);

  // duration registers
  logic [DUR_W-1:0] start_dur_q, short_dur_q, long_dur_q;

  // sequencer state
  enc_state_e          state_q, state_d;
  logic [BCW-1:0]      bit_cnt_q, bit_cnt_d;
  logic [SCW-1:0]      seg_cnt_q, seg_cnt_d;
  logic                phase_q, phase_d;
  logic                out_valid_q, out_valid_d;

  // frame payload
  logic [TOT_BITS-1:0] shift_q, shift_d;
  logic                level_q, level_d;
  logic                action_q, action_d;
  logic                hold_q, hold_d;
  segment_t            seg_q, seg_d;

  logic                frame_acc;
  logic                advance;
  logic                emit;
  logic                bit_done;
  logic                cur_bit;
  logic [ID_BITS_MAX-1:0]  id_ext;
  logic [KEY_BITS_MAX-1:0] key_ext;

  assign frame_acc     = frame_i.valid && frame_i.ready;
  assign advance       = !out_valid_q || seg_o.ready;
  assign frame_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign seg_o.valid   = out_valid_q;
  assign seg_o.data    = seg_q;

  assign id_ext  = ID_BITS_MAX'(frame_i.data.remote_id);
  assign key_ext = KEY_BITS_MAX'(frame_i.data.key_code);
  assign cur_bit = shift_q[TOT_BITS-1];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_dur_q <= START_DUR_RST;
      short_dur_q <= SHORT_DUR_RST;
      long_dur_q  <= LONG_DUR_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.data.index))
        REG_START_DUR: start_dur_q <= cfg_i.data.value;
        REG_SHORT_DUR: short_dur_q <= cfg_i.data.value;
        REG_LONG_DUR:  long_dur_q  <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      seg_cnt_q   <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      seg_cnt_q   <= seg_cnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    shift_q  <= shift_d;
    level_q  <= level_d;
    action_q <= action_d;
    hold_q   <= hold_d;
    seg_q    <= seg_d;
  end

  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    seg_cnt_d   = seg_cnt_q;
    phase_d     = phase_q;
    shift_d     = shift_q;
    level_d     = level_q;
    action_d    = action_q;
    hold_d      = hold_q;
    seg_d       = seg_q;
    emit        = 1'b0;
    bit_done    = 1'b0;
    out_valid_d = out_valid_q && !seg_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (frame_acc) begin
          shift_d   = {id_ext[ID_BITS-1:0], key_ext[KEY_BITS-1:0]};
          action_d  = frame_i.data.action;
          hold_d    = frame_i.data.append_hold;
          level_d   = frame_i.data.action;
          bit_cnt_d = BCW'(TOT_BITS);
          seg_cnt_d = '0;
          phase_d   = 1'b0;
          state_d   = ST_START;
        end
      end
      ST_START: begin
        if (advance) begin
          emit              = 1'b1;
          seg_d.line_level  = action_q;
          seg_d.duration_us = start_dur_q;
          seg_d.last_segment = 1'b0;
          state_d           = ST_BIT;
        end
      end
      ST_BIT: begin
        if (advance) begin
          emit               = 1'b1;
          seg_d.last_segment = 1'b0;
          if (cur_bit) begin
            // one bit: single long segment, level flips
            seg_d.line_level  = !level_q;
            seg_d.duration_us = long_dur_q;
            level_d           = !level_q;
            bit_done          = 1'b1;
          end else if (!phase_q) begin
            // zero bit, first half at the opposite level
            seg_d.line_level  = !level_q;
            seg_d.duration_us = short_dur_q;
            phase_d           = 1'b1;
          end else begin
            // zero bit, second half back at the tracked level
            seg_d.line_level  = level_q;
            seg_d.duration_us = short_dur_q;
            phase_d           = 1'b0;
            bit_done          = 1'b1;
          end
          if (bit_done) begin
            shift_d   = shift_q << 1;
            bit_cnt_d = bit_cnt_q - BCW'(1);
            if (bit_cnt_q == BCW'(1)) begin
              if (hold_q) begin
                state_d = ST_HOLD;
              end else begin
                seg_d.last_segment = 1'b1;
                state_d            = ST_IDLE;
              end
            end
          end
        end
      end
      ST_HOLD: begin
        if (advance) begin
          emit               = 1'b1;
          seg_d.line_level   = action_q;
          seg_d.duration_us  = HOLD_DUR;
          seg_d.last_segment = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
      seg_cnt_d   = seg_cnt_q + SCW'(1);
      // frame cut at the segment cap
      if (seg_cnt_q == SCW'(MAX_SEGMENTS - 1)) begin
        seg_d.last_segment = 1'b1;
        state_d            = ST_IDLE;
      end
    end
  end

  // an accepted frame always opens with the start segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_acc |=> state_q == ST_START)
    else $error("frame accept did not enter start state");

  // a segment marked last returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && seg_d.last_segment) |=> state_q == ST_IDLE)
    else $error("last segment sent but sequencer still busy");

  // the hold segment sits at the action level with zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && state_q == ST_HOLD) |=>
      (seg_q.duration_us == HOLD_DUR && seg_q.line_level == action_q))
    else $error("bad hold segment");

  // bit state always has bits left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BIT |-> bit_cnt_q != '0)
    else $error("bit state with empty bit counter");

  // an emitted segment is never dropped by a stalled receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !seg_o.ready) |-> !emit)
    else $error("segment overwritten while stalled");

endmodule

/* tb/rf_remote_pulse_encoder_tb.sv */
`timescale 1ns / 1ps

module rf_remote_pulse_encoder_tb
  import rfpe_pkg::*;
#(
  parameter int unsigned ID_BITS  = ID_BITS_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
);

  // run shape
  localparam int unsigned RANDOM_FRAMES = 180;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 10;

  // the index field has one code with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // receiver stall patterns
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_PERIODIC,
    SINK_BURSTY
  } sink_mode_e;

  logic clk;
  logic rst_n;

  rfpe_chan_if #(.payload_t(frame_t))   frame_if ();
  rfpe_chan_if #(.payload_t(cfg_wr_t))  cfg_if ();
  rfpe_chan_if #(.payload_t(segment_t)) seg_if ();

  rf_remote_pulse_encoder #(
    .ID_BITS (ID_BITS),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .frame_i(frame_if),
    .cfg_i (cfg_if),
    .seg_o (seg_if)
  );

  // shadow copy of the duration registers
  logic [DUR_W-1:0] dur_start;
  logic [DUR_W-1:0] dur_short;
  logic [DUR_W-1:0] dur_long;

  // segments still owed by the block, oldest first
  segment_t pending_segments[$];
  // scratch list while one frame is being worked out
  segment_t frame_plan[$];
  logic     plan_level;

  int unsigned error_count;
  int unsigned burst_left;
  int unsigned cycle_count;

  // clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // frame predictor
  // ---------------------------------------------------------------------------

  // append one segment unless the frame already hit the segment cap
  function automatic void plan_segment(logic lvl, logic [DUR_W-1:0] dur);
    segment_t s;
    if (frame_plan.size() < MAX_SEGMENTS) begin
      s.line_level   = lvl;
      s.duration_us  = dur;
      s.last_segment = 1'b0;
      frame_plan.push_back(s);
    end
  endfunction

  // one bit: zero is short out and back, one is a long flip of the level
  function automatic void plan_bit(logic b);
    if (b) begin
      plan_segment(~plan_level, dur_long);
      plan_level = ~plan_level;
    end else begin
      plan_segment(~plan_level, dur_short);
      plan_segment(plan_level, dur_short);
    end
  endfunction

  // whole frame: start, id bits, key bits, optional hold, last flag on the tail
  function automatic void predict_frame(frame_t f);
    int       i;
    logic     b;
    segment_t tail;
    frame_plan.delete();
    plan_level = f.action;
    plan_segment(f.action, dur_start);
    for (i = int'(ID_BITS) - 1; i >= 0; i--) begin
      // bits beyond the 16-bit id field go out as zero
      b = (i < ID_FIELD_W) ? f.remote_id[i] : 1'b0;
      plan_bit(b);
    end
    for (i = int'(KEY_BITS) - 1; i >= 0; i--) begin
      // bits beyond the 7-bit key field go out as zero
      b = (i < KEY_FIELD_W) ? f.key_code[i] : 1'b0;
      plan_bit(b);
    end
    if (f.append_hold) begin
      plan_segment(f.action, HOLD_DUR);
    end
    tail = frame_plan.pop_back();
    tail.last_segment = 1'b1;
    frame_plan.push_back(tail);
    foreach (frame_plan[k]) begin
      pending_segments.push_back(frame_plan[k]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // frame sender: bursts of back-to-back words with random gaps between
  // ---------------------------------------------------------------------------

  function automatic frame_t make_frame(logic [ID_FIELD_W-1:0] id,
                                        logic [KEY_FIELD_W-1:0] key,
                                        logic act, logic hold);
    frame_t f;
    f.remote_id   = id;
    f.key_code    = key;
    f.action      = act;
    f.append_hold = hold;
    return f;
  endfunction

  task automatic send_frame(frame_t f);
    int unsigned gap;
    if (burst_left == 0) begin
      // valid goes low for a random gap first, so it never drops and rises in one step
      frame_if.valid <= 1'b0;
      gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 6);
      repeat (gap) @(posedge clk);
      // mostly short bursts, now and then a long stretch with no idling
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
    end
    frame_if.valid <= 1'b1;
    frame_if.data  <= f;
    do @(posedge clk); while (!frame_if.ready);
    predict_frame(f);
    burst_left--;
  endtask

  // stop sending and wait until the block has delivered everything it owes
  task automatic drain_frames();
    frame_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_segments.size() != 0 || !frame_if.ready);
  endtask

  // ---------------------------------------------------------------------------
  // register writes, only ever issued while the block is idle
  // ---------------------------------------------------------------------------

  // leaves valid high so writes can go back to back; caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] value);
    cfg_wr_t w;
    w.index = idx;
    w.value = value;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_START_DUR: dur_start = value;
      REG_SHORT_DUR: dur_short = value;
      REG_LONG_DUR:  dur_long  = value;
      default: ;
    endcase
  endtask

  task automatic program_durations(logic [DUR_W-1:0] start_us,
                                   logic [DUR_W-1:0] short_us,
                                   logic [DUR_W-1:0] long_us);
    write_reg(REG_START_DUR, start_us);
    write_reg(REG_SHORT_DUR, short_us);
    write_reg(REG_LONG_DUR, long_us);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // segment receiver: the stall pattern is redrawn at random, so ready varies across cycles
  // ---------------------------------------------------------------------------

  initial begin
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned stall_left;
    int unsigned phase;
    seg_if.ready = 1'b0;
    mode       = SINK_OPEN;
    mode_left  = 0;
    stall_left = 0;
    phase      = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      phase++;
      case (mode)
        SINK_OPEN:     seg_if.ready <= 1'b1;
        SINK_COIN:     seg_if.ready <= 1'($urandom_range(0, 1));
        SINK_PERIODIC: seg_if.ready <= (phase % 4 != 0);
        default: begin
          // occasional stalls of random length
          if (stall_left != 0) begin
            stall_left--;
            seg_if.ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 5);
            seg_if.ready <= 1'b0;
          end else begin
            seg_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // segment checker: each accepted word against the oldest owed segment
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    segment_t want;
    segment_t got;
    if (rst_n && seg_if.valid && seg_if.ready) begin
      got = seg_if.data;
      if (pending_segments.size() == 0) begin
        if (error_count < MAX_REPORTS) begin
          $display("%0t: segment with nothing owed: level=%0b dur=%0d last=%0b",
                   $time, got.line_level, got.duration_us, got.last_segment);
        end
        error_count++;
      end else begin
        want = pending_segments.pop_front();
        if (got.line_level !== want.line_level ||
            got.duration_us !== want.duration_us ||
            got.last_segment !== want.last_segment) begin
          if (error_count < MAX_REPORTS) begin
            $write("%0t: segment mismatch: expected level=%0b dur=%0d last=%0b, ",
                   $time, want.line_level, want.duration_us, want.last_segment);
            $display("got level=%0b dur=%0d last=%0b",
                     got.line_level, got.duration_us, got.last_segment);
          end
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes and bit patterns at the reset durations
  task automatic test_reset_durations();
    send_frame(make_frame(16'h0000, 7'h00, 1'b0, 1'b0));
    send_frame(make_frame(16'hFFFF, 7'h7F, 1'b1, 1'b1));
    send_frame(make_frame(16'hFFFF, 7'h7F, 1'b0, 1'b0));
    send_frame(make_frame(16'h0000, 7'h00, 1'b1, 1'b1));
    send_frame(make_frame(16'hAAAA, 7'h55, 1'b1, 1'b0));
    send_frame(make_frame(16'h5555, 7'h2A, 1'b0, 1'b1));
    send_frame(make_frame(16'h8001, 7'h40, 1'b1, 1'b1));
    send_frame(make_frame(16'h7FFE, 7'h01, 1'b0, 1'b0));
    drain_frames();
  endtask

  // shortest, longest and zero durations; zero goes out as a hold length
  task automatic test_duration_extremes();
    program_durations(16'd1, 16'd1, 16'd1);
    send_frame(make_frame(16'hFFFF, 7'h00, 1'b1, 1'b1));
    send_frame(make_frame(16'h0000, 7'h7F, 1'b0, 1'b0));
    send_frame(make_frame(16'hC3A5, 7'h5A, 1'b1, 1'b0));
    drain_frames();
    program_durations(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(make_frame(16'h0F0F, 7'h70, 1'b0, 1'b1));
    send_frame(make_frame(16'hF0F0, 7'h0F, 1'b1, 1'b1));
    send_frame(make_frame(16'h1234, 7'h33, 1'b0, 1'b0));
    drain_frames();
    program_durations(16'd0, 16'd0, 16'd0);
    send_frame(make_frame(16'hFFFF, 7'h7F, 1'b1, 1'b1));
    send_frame(make_frame(16'h0000, 7'h00, 1'b0, 1'b1));
    send_frame(make_frame(16'hBEEF, 7'h6D, 1'b1, 1'b0));
    drain_frames();
  endtask

  // writes to the spare index must leave all three durations alone
  task automatic test_unused_register();
    write_reg(REG_START_DUR, 16'd700);
    write_reg(REG_SHORT_DUR, 16'd120);
    write_reg(REG_LONG_DUR, 16'd333);
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h0000);
    cfg_if.valid <= 1'b0;
    send_frame(make_frame(16'h9C31, 7'h4B, 1'b1, 1'b1));
    send_frame(make_frame(16'h63CE, 7'h34, 1'b0, 1'b0));
    drain_frames();
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 5))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 16));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // random frames in phases, each phase with its own register setting
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned phase_len;
    frame_t      f;
    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      drain_frames();
      program_durations(pick_duration(), pick_duration(), pick_duration());
      phase_len = $urandom_range(20, 50);
      while (phase_len != 0 && sent < RANDOM_FRAMES) begin
        f.remote_id   = 16'($urandom);
        f.key_code    = 7'($urandom);
        f.action      = 1'($urandom);
        f.append_hold = 1'($urandom);
        // now and then an all-zero or all-one id to stretch or shorten the frame
        if ($urandom_range(0, 9) == 0) begin
          f.remote_id = {ID_FIELD_W{f.action}};
        end
        send_frame(f);
        // now and then the sender holds off until the block has caught up
        if ($urandom_range(0, 24) == 0) begin
          drain_frames();
        end
        phase_len--;
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    frame_if.valid = 1'b0;
    frame_if.data  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    error_count    = 0;
    burst_left     = 0;
    dur_start      = START_DUR_RST;
    dur_short      = SHORT_DUR_RST;
    dur_long       = LONG_DUR_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_durations();
    test_duration_extremes();
    test_unused_register();
    test_random_frames();

    drain_frames();
    // catch any stray segment after the last frame
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* rf_remote_pulse_encoder.f */
src/rfpe_pkg.sv
src/rfpe_chan_if.sv
src/rf_remote_pulse_encoder.sv
tb/rf_remote_pulse_encoder_tb.sv
